FILE: rtl/mfpe_pkg.sv
// Shared types and constants for the frame payload extractor.
`default_nettype none

package mfpe_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 32;

    // Reset value of the mandatory header size register.
    localparam logic [BYTE_W-1:0] MIN_HDR_RESET = 8'd12;

    // One header word is four bytes.
    localparam logic [LEN_W-1:0] HDR_WORD_BYTES = 32'd4;

    // Version value that announces the optional header word.
    localparam logic [BYTE_W-1:0] VER_WITH_OPT = 8'd1;

    // Bit of the third sample-flag byte that announces the skip-size word.
    localparam int unsigned SKIP_FLAG_BIT = 1;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_last;
    } t_out_item;

endpackage

`default_nettype wire

FILE: rtl/mux_frame_payload_extractor.sv
// Top level of the frame payload extractor.
//
// Takes one stream byte per word and passes on only the payload bytes of each
// frame, dropping the header words and the skip run; m_tlast marks the last
// payload byte of a frame, and s_tlast (end of a software buffer) has no effect.
// A byte is accepted on every clock while the output keeps draining, and its
// result is held first in the input register and then goes through the header
// parser into the result register. s_tready drops only while the result
// register holds a word that m_tready has not taken. The mandatory header
// size is written through the cfg channel, which is always ready; write it
// only while no frame is in flight.
`default_nettype none

module mux_frame_payload_extractor (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output      logic       o_cfg_ready,
    input  wire logic [7:0] i_cfg_data,   // min_header_size
    input  wire logic       s_tvalid,
    output      logic       s_tready,
    input  wire logic [7:0] s_tdata,      // data_byte
    input  wire logic       s_tlast,      // chunk_end
    output      logic       m_tvalid,
    input  wire logic       m_tready,
    output      logic [7:0] m_tdata,      // payload_byte
    output      logic       m_tlast       // frame_last
);
    import mfpe_pkg::*;

    logic              w_in_valid;
    logic [BYTE_W-1:0] w_in_data;
    logic              w_consume;
    t_out_item         w_item;

    assign o_cfg_ready = 1'b1;

    mfpe_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_tvalid),
        .o_ready   (s_tready),
        .i_data    (s_tdata),
        .o_valid   (w_in_valid),
        .o_data    (w_in_data),
        .i_consume (w_consume)
    );

    mfpe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (w_in_valid),
        .i_in_data   (w_in_data),
        .o_consume   (w_consume),
        .o_valid     (m_tvalid),
        .o_item      (w_item),
        .i_take      (m_tready)
    );

    assign m_tdata = w_item.payload_byte;
    assign m_tlast = w_item.frame_last;

    // Input is only held back by a result that waits at the output.
    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while the output was free");

    // A full input register that is not consumed means the output is stalled.
    a_hold_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && !w_consume) |-> (m_tvalid && !m_tready))
        else $error("input register held without an output stall");

    // A new result can only come from a byte that sat in the input register.
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(w_in_valid))
        else $error("result appeared without a source byte");

endmodule

`default_nettype wire

FILE: rtl/mfpe_in_reg.sv
// Input register stage of the frame payload extractor.
`default_nettype none

module mfpe_in_reg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output      logic                       o_ready,
    input  wire logic [mfpe_pkg::BYTE_W-1:0] i_data,
    output      logic                       o_valid,
    output      logic [mfpe_pkg::BYTE_W-1:0] o_data,
    input  wire logic                       i_consume
);
    import mfpe_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_data;

    // The stage frees up in the same cycle that the parser takes its word.
    assign o_ready = !r_valid || i_consume;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mfpe_parser.sv
// Header parser, length counters and result register of the frame payload extractor.
`default_nettype none

module mfpe_parser (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    input  wire logic [mfpe_pkg::BYTE_W-1:0] i_cfg_data,
    input  wire logic                        i_in_valid,
    input  wire logic [mfpe_pkg::BYTE_W-1:0] i_in_data,
    output      logic                        o_consume,
    output      logic                        o_valid,
    output      mfpe_pkg::t_out_item         o_item,
    input  wire logic                        i_take
);
    import mfpe_pkg::*;

    localparam logic [2:0] PH_TOTAL   = 3'd0;
    localparam logic [2:0] PH_VER     = 3'd1;
    localparam logic [2:0] PH_SAMPLE  = 3'd2;
    localparam logic [2:0] PH_OPT     = 3'd3;
    localparam logic [2:0] PH_SKIPSZ  = 3'd4;
    localparam logic [2:0] PH_SKIP    = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;

    localparam logic [1:0] LAST_BYTE_IDX = 2'd3;

    logic [BYTE_W-1:0] r_min_hdr;
    logic [2:0]        r_phase,    n_phase;
    logic [1:0]        r_byte_idx, n_byte_idx;
    logic [23:0]       r_word,     n_word;
    logic [LEN_W-1:0]  r_pay_rem,  n_pay_rem;
    logic [LEN_W-1:0]  r_skip_rem, n_skip_rem;
    logic              r_opt,      n_opt;
    logic              r_skp,      n_skp;
    logic              r_valid;
    t_out_item         r_item;

    logic              w_emit;
    logic              w_last;
    logic              w_hdr;
    logic [2:0]        w_hdr_phase;
    logic [LEN_W-1:0]  w_word;
    logic              w_skp_flag;

    // The parser advances only when the result register can take the outcome.
    assign o_consume = i_in_valid && (!r_valid || i_take);
    assign o_valid   = r_valid;
    assign o_item    = r_item;

    assign w_word     = {r_word, i_in_data};
    assign w_skp_flag = w_word[BYTE_W + SKIP_FLAG_BIT];

    always_comb begin
        n_phase     = r_phase;
        n_byte_idx  = r_byte_idx;
        n_word      = r_word;
        n_pay_rem   = r_pay_rem;
        n_skip_rem  = r_skip_rem;
        n_opt       = r_opt;
        n_skp       = r_skp;
        w_emit      = 1'b0;
        w_last      = 1'b0;
        w_hdr       = 1'b0;
        w_hdr_phase = PH_TOTAL;

        // A spent skip count falls into the payload, and a spent payload
        // count falls into the next frame's header, all within one byte.
        unique case (r_phase)
            PH_SKIP: begin
                if (r_skip_rem != '0) begin
                    n_skip_rem = r_skip_rem - LEN_W'(1);
                end else if (r_pay_rem != '0) begin
                    n_phase   = PH_PAYLOAD;
                    n_pay_rem = r_pay_rem - LEN_W'(1);
                    w_emit    = 1'b1;
                    w_last    = (r_pay_rem == LEN_W'(1));
                end else begin
                    w_hdr = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                if (r_pay_rem != '0) begin
                    n_pay_rem = r_pay_rem - LEN_W'(1);
                    w_emit    = 1'b1;
                    w_last    = (r_pay_rem == LEN_W'(1));
                end else begin
                    w_hdr = 1'b1;
                end
            end
            PH_TOTAL, PH_VER, PH_SAMPLE, PH_OPT, PH_SKIPSZ: begin
                w_hdr       = 1'b1;
                w_hdr_phase = r_phase;
            end
            default: begin
                w_hdr = 1'b1;
            end
        endcase

        if (w_hdr) begin
            if (r_byte_idx != LAST_BYTE_IDX) begin
                n_phase    = w_hdr_phase;
                n_byte_idx = r_byte_idx + 2'd1;
                n_word     = w_word[23:0];
            end else begin
                n_byte_idx = '0;
                n_word     = '0;
                unique case (w_hdr_phase)
                    PH_TOTAL: begin
                        n_pay_rem = w_word - {{(LEN_W-BYTE_W){1'b0}}, r_min_hdr};
                        n_phase   = PH_VER;
                    end
                    PH_VER: begin
                        n_opt   = (w_word[LEN_W-1 -: BYTE_W] == VER_WITH_OPT);
                        n_phase = PH_SAMPLE;
                    end
                    PH_SAMPLE: begin
                        n_skp = w_skp_flag;
                        if (r_opt) begin
                            n_phase = PH_OPT;
                        end else if (w_skp_flag) begin
                            n_phase = PH_SKIPSZ;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_OPT: begin
                        n_pay_rem = r_pay_rem - HDR_WORD_BYTES;
                        n_phase   = r_skp ? PH_SKIPSZ : PH_SKIP;
                    end
                    default: begin
                        // Skip-size word: the word itself and the skip run both
                        // come off the payload, which nets to the word value.
                        n_skip_rem = w_word - HDR_WORD_BYTES;
                        n_pay_rem  = r_pay_rem - w_word;
                        n_phase    = PH_SKIP;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_hdr  <= MIN_HDR_RESET;
            r_phase    <= PH_TOTAL;
            r_byte_idx <= '0;
            r_word     <= '0;
            r_pay_rem  <= '0;
            r_skip_rem <= '0;
            r_opt      <= 1'b0;
            r_skp      <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_min_hdr <= i_cfg_data;
            end
            if (o_consume) begin
                r_phase    <= n_phase;
                r_byte_idx <= n_byte_idx;
                r_word     <= n_word;
                r_pay_rem  <= n_pay_rem;
                r_skip_rem <= n_skip_rem;
                r_opt      <= n_opt;
                r_skp      <= n_skp;
                r_valid    <= w_emit;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_consume && w_emit) begin
            r_item.payload_byte <= i_in_data;
            r_item.frame_last   <= w_last;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the frame payload extractor, with a queue-fed driver and a monitor.

module tb_top;
    import mfpe_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned PHASE_BYTES   = 240;
    localparam int unsigned WRAP_BYTES    = 40;
    localparam int unsigned MAX_REPORTS   = 10;

    typedef enum logic [2:0] {
        HDR_TOTAL,
        HDR_VERSION,
        HDR_SAMPLE,
        HDR_OPTIONAL,
        HDR_SKIP_SIZE,
        SKIP_RUN,
        PAYLOAD_RUN
    } t_parse_phase;

    typedef struct {
        logic [7:0] data;
        logic       chunk_end;
    } t_stream_byte;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data  = 8'd0;
    logic       s_tvalid    = 1'b0;
    logic [7:0] s_tdata     = 8'd0;
    logic       s_tlast     = 1'b0;
    logic       m_tready    = 1'b0;
    logic       o_cfg_ready;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic       m_tlast;

    mux_frame_payload_extractor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state.
    logic [BYTE_W-1:0] header_min;
    t_parse_phase      parse_phase;
    logic [1:0]        hdr_count;
    logic [LEN_W-1:0]  hdr_word;
    logic [LEN_W-1:0]  pay_count;
    logic [LEN_W-1:0]  skip_count;
    logic              has_opt_word;
    logic              has_skip_word;

    t_stream_byte pending_bytes[$];
    t_out_item    expected_payload[$];

    bit          send_idle     = 1'b1;
    bit          recv_idle     = 1'b1;
    int unsigned hold_len_req  = 0;
    int unsigned hold_count    = 0;
    logic        hold_off      = 1'b0;
    int unsigned cycle_count   = 0;
    int unsigned mismatch_count = 0;
    int unsigned bytes_pushed  = 0;
    int unsigned bytes_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned frames_built  = 0;
    int unsigned cfg_writes    = 0;

    function automatic void reset_predictor();
        header_min    = MIN_HDR_RESET;
        parse_phase   = HDR_TOTAL;
        hdr_count     = '0;
        hdr_word      = '0;
        pay_count     = '0;
        skip_count    = '0;
        has_opt_word  = 1'b0;
        has_skip_word = 1'b0;
    endfunction

    // Advances the predictor by one stream byte; returns 1 when a payload byte comes out.
    function automatic bit extract_step(input logic [7:0] b, output t_out_item res);
        res = '0;
        if (parse_phase == SKIP_RUN) begin
            if (skip_count != 0) begin
                skip_count = skip_count - 1;
                return 1'b0;
            end
            parse_phase = PAYLOAD_RUN;
        end
        if (parse_phase == PAYLOAD_RUN) begin
            if (pay_count != 0) begin
                pay_count        = pay_count - 1;
                res.payload_byte = b;
                res.frame_last   = (pay_count == 0);
                return 1'b1;
            end
            parse_phase = HDR_TOTAL;
        end
        hdr_word  = {hdr_word[23:0], b};
        hdr_count = hdr_count + 2'd1;
        if (hdr_count == 2'd0) begin
            case (parse_phase)
                HDR_TOTAL: begin
                    pay_count = hdr_word - LEN_W'(header_min);
                end
                HDR_VERSION: begin
                    has_opt_word = (hdr_word[31:24] == VER_WITH_OPT);
                end
                HDR_SAMPLE: begin
                    has_skip_word = hdr_word[8 + SKIP_FLAG_BIT];
                end
                HDR_OPTIONAL: begin
                    pay_count = pay_count - HDR_WORD_BYTES;
                end
                default: begin
                    skip_count = hdr_word - HDR_WORD_BYTES;
                    pay_count  = pay_count - HDR_WORD_BYTES - skip_count;
                end
            endcase
            parse_phase = t_parse_phase'(parse_phase + 1);
            if (parse_phase == HDR_OPTIONAL && !has_opt_word)
                parse_phase = HDR_SKIP_SIZE;
            if (parse_phase == HDR_SKIP_SIZE && !has_skip_word)
                parse_phase = SKIP_RUN;
            hdr_word = '0;
        end
        return 1'b0;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        t_stream_byte item;
        item.data      = b;
        item.chunk_end = ($urandom_range(0, 7) == 0);
        pending_bytes.push_back(item);
        bytes_pushed++;
    endfunction

    function automatic void push_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            push_byte(w[8*i +: 8]);
    endfunction

    // Builds one consistent frame; the total length is derived from the chosen parts.
    function automatic void push_frame(input bit opt, input bit skw, input logic [31:0] ver,
                                       input logic [31:0] flags, input int unsigned skip_n,
                                       input int unsigned pay_n, input bit extreme_fill);
        logic [31:0] total;
        if (!skw)
            skip_n = 0;
        total = LEN_W'(header_min) + (opt ? 32'd4 : 32'd0) + (skw ? 32'd4 : 32'd0)
              + skip_n + pay_n;
        push_word(total);
        push_word(ver);
        push_word(flags);
        if (opt)
            push_word($urandom);
        if (skw)
            push_word(HDR_WORD_BYTES + skip_n);
        repeat (skip_n) push_byte(8'($urandom));
        for (int i = 0; i < pay_n; i++)
            push_byte(extreme_fill ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom));
        frames_built++;
    endfunction

    function automatic void push_random_frame();
        bit          opt;
        bit          skw;
        int unsigned skip_n;
        int unsigned pay_n;
        int unsigned sel;
        logic [31:0] ver;
        logic [31:0] flags;
        opt    = 1'($urandom_range(0, 1));
        skw    = 1'($urandom_range(0, 1));
        skip_n = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
        sel    = $urandom_range(0, 19);
        if (sel < 2)
            pay_n = 0;
        else if (sel < 18)
            pay_n = $urandom_range(1, 16);
        else
            pay_n = $urandom_range(17, 200);
        ver = $urandom;
        if (opt) begin
            ver[31:24] = VER_WITH_OPT;
        end else begin
            case ($urandom_range(0, 3))
                0: ver[31:24] = 8'h00;
                1: ver[31:24] = 8'h02;
                2: ver[31:24] = 8'hFF;
                default: if (ver[31:24] == VER_WITH_OPT) ver[31:24] = 8'h81;
            endcase
        end
        flags = $urandom;
        flags[8 + SKIP_FLAG_BIT] = skw;
        push_frame(opt, skw, ver, flags, skip_n, pay_n, 1'b0);
    endfunction

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_tvalid || expected_payload.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_header_min(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        header_min = value;
        cfg_writes++;
    endtask

    // Sender: one word per handshake, with a random gap drawn per word while send_idle is set.
    int unsigned send_gap = 0;
    always @(posedge i_clk) begin
        t_stream_byte item;
        t_out_item    res;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                bytes_sent++;
                if (extract_step(s_tdata, res))
                    expected_payload.push_back(res);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    item = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= item.data;
                    s_tlast  <= item.chunk_end;
                    send_gap = send_idle ? $urandom_range(0, 9) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off, so the block fills up and back-pressures its input.
    always @(posedge i_clk) begin
        if (hold_count < hold_len_req) begin
            hold_count <= hold_count + 1;
            hold_off   <= 1'b1;
        end else begin
            hold_off <= 1'b0;
        end
    end

    // Receiver: checks each word against the oldest expectation.
    int unsigned recv_wait = 0;
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_payload.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("Unexpected payload word: data %02h last %0b",
                                 m_tdata, m_tlast);
                end else begin
                    want = expected_payload.pop_front();
                    if (m_tdata !== want.payload_byte || m_tlast !== want.frame_last) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("Mismatch: expected %02h last %0b, got %02h last %0b",
                                     want.payload_byte, want.frame_last, m_tdata, m_tlast);
                    end
                end
                recv_wait = recv_idle ? $urandom_range(0, 9) : 0;
            end
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out with %0d bytes pending and %0d results outstanding.",
                     pending_bytes.size(), expected_payload.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [7:0] setting;
        int unsigned target;
        reset_predictor();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset header size.
        push_frame(1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 0, 1, 1'b1);
        push_frame(1'b0, 1'b0, 32'hFF00_0000, 32'hFFFF_FDFF, 0, 0, 1'b0);
        push_frame(1'b1, 1'b0, 32'h0100_0000, 32'h0000_0000, 0, 2, 1'b1);
        push_frame(1'b0, 1'b1, 32'h0200_0000, 32'h0000_0200, 0, 2, 1'b1);
        push_frame(1'b1, 1'b1, 32'h01FF_FFFF, 32'hFFFF_FFFF, 3, 4, 1'b1);
        push_frame(1'b0, 1'b1, 32'h00FF_FFFF, 32'h0000_0200, 5, 0, 1'b0);
        wait_idle();

        for (int k = 0; k < 5; k++) begin
            case (k)
                0: setting = 8'd0;
                1: setting = 8'd255;
                2, 3: setting = 8'($urandom_range(1, 254));
                default: setting = MIN_HDR_RESET;
            endcase
            write_header_min(setting);
            send_idle <= (k != 1 && k != 3);
            recv_idle <= (k != 1 && k != 4);
            if (k == 1)
                hold_len_req <= HOLD_CYCLES;
            target = bytes_pushed + PHASE_BYTES;
            while (bytes_pushed < target)
                push_random_frame();
            wait_idle();
        end

        // A total length below the header size wraps the payload count, so every
        // following byte comes out as payload without the frame end flag.
        send_idle <= 1'b1;
        recv_idle <= 1'b1;
        push_word(32'd3);
        push_word(32'h0000_0000);
        push_word(32'h0000_0000);
        repeat (WRAP_BYTES) push_byte(8'($urandom));
        wait_idle();

        $display("Sent %0d bytes in %0d frames plus a wrapped length, %0d header size writes.",
                 bytes_sent, frames_built, cfg_writes);
        $display("Checked %0d payload words with %0d mismatches.", results_seen, mismatch_count);
        if (mismatch_count == 0 && expected_payload.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mfpe_pkg.sv
rtl/mfpe_in_reg.sv
rtl/mfpe_parser.sv
rtl/mux_frame_payload_extractor.sv
tb/sv/tb_top.sv
